// ----- rtl/twc_pkg.sv -----
// Package for the thresholded weighted centroid block.
// Holds widths, register codes, reset values and the payload and control types.
// Has no dependencies and is used by every module of the block.
package twc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FID_W      = 32;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SUM_W      = 30;
  localparam int unsigned WT_W       = 28;
  localparam int unsigned WSUM_W     = 38;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CEN_W      = 18;
  localparam int unsigned CONF_W     = 17;
  localparam int unsigned SCALE_W    = 12;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned PXP_W      = PIX_W + COL_W;
  localparam int unsigned DIV_NUM_W  = WSUM_W + FRAC_BITS;
  localparam int unsigned DIV_DEN_W  = 28;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned PROD_W     = CONF_W + SCALE_W;
  localparam int unsigned CONF_RAW_W = PROD_W - FRAC_BITS;
  localparam int unsigned M9_W       = CNT_W + 4;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [DIM_W-1:0]     MAX_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]     MAX_HEIGHT = 11'd1024;
  localparam logic [CONF_W-1:0]    CONF_ONE   = 17'd65536;
  localparam logic [CEN_W-1:0]     CEN_MAX    = 18'd262143;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = DIV_CNT_W'(DIV_NUM_W);

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PIXELS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONF_SCALE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [THR_W-1:0]   RST_THRESHOLD    = 8'd200;
  localparam logic [CNT_W-1:0]   RST_MIN_PIXELS   = 21'd20;
  localparam logic [SCALE_W-1:0] RST_CONF_SCALE   = 12'd256;
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [FID_W-1:0] frame_tag;
  } pix_in_t;

  typedef struct packed {
    logic [FID_W-1:0]  frame_id_out;
    logic [CEN_W-1:0]  centroid_x;
    logic [CEN_W-1:0]  centroid_y;
    logic [CONF_W-1:0] confidence;
  } est_out_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [CNT_W-1:0]   min_bright;
    logic [SCALE_W-1:0] conf_gain;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_X = 2'd0,
    DIV_Y = 2'd1,
    DIV_C = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     acc_en;
    logic     snap;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_x;
    logic     cap_y;
    logic     cap_c;
    logic     mul_en;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic div_done;
    logic out_full;
  } ctrl_sts_t;

endpackage

// ----- rtl/twc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on twc_pkg for the operand widths and the step count.
module twc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [twc_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [twc_pkg::DIV_DEN_W-1:0]    den_i,
  output logic                             done_o,
  output logic [twc_pkg::DIV_NUM_W-1:0]    quot_o
);

  logic [twc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          active_q, active_d;
  logic [twc_pkg::DIV_NUM_W-1:0] num_q, num_d;
  logic [twc_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [twc_pkg::DIV_DEN_W-1:0] den_q, den_d;
  logic [twc_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  assign trial = {rem_q, num_q[twc_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    num_d    = num_q;
    rem_d    = rem_q;
    den_d    = den_q;
    if (start_i) begin
      cnt_d    = twc_pkg::DIV_STEPS;
      active_d = 1'b1;
      num_d    = num_i;
      rem_d    = '0;
      den_d    = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - twc_pkg::DIV_CNT_W'(1);
      num_d = {num_q[twc_pkg::DIV_NUM_W-2:0], fits};
      rem_d = fits ? twc_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                   : trial[twc_pkg::DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = active_q && (cnt_q == '0);
  assign quot_o = num_q;

endmodule

// ----- rtl/twc_dp.sv -----
// Datapath: raster position, bright-pixel accumulators, frame snapshot,
// shared divider, confidence multiplier and the result register.
// Depends on twc_pkg and instantiates twc_div.
module twc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  twc_pkg::cfg_t              cfg_i,
  input  twc_pkg::pix_in_t           in_data_i,
  input  twc_pkg::ctrl_cmd_t         cmd_i,
  output twc_pkg::ctrl_sts_t         sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output twc_pkg::est_out_t          out_data_o
);

  logic [twc_pkg::COL_W-1:0]  col_q, col_d, row_q, row_d;
  logic [twc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [twc_pkg::SUM_W-1:0]  scol_q, scol_d, srow_q, srow_d;
  logic [twc_pkg::WT_W-1:0]   wt_q, wt_d;
  logic [twc_pkg::WSUM_W-1:0] wcol_q, wcol_d, wrow_q, wrow_d;

  logic [twc_pkg::CNT_W-1:0]  s_cnt_q;
  logic [twc_pkg::SUM_W-1:0]  s_scol_q, s_srow_q;
  logic [twc_pkg::WT_W-1:0]   s_wt_q;
  logic [twc_pkg::WSUM_W-1:0] s_wcol_q, s_wrow_q;
  logic [twc_pkg::FID_W-1:0]  s_fid_q;

  logic [twc_pkg::CEN_W-1:0]  cx_q, cy_q;
  logic [twc_pkg::CONF_W-1:0] c1_q;
  logic [twc_pkg::PROD_W-1:0] prod_q;
  logic                       out_valid_q;
  twc_pkg::est_out_t          out_q;

  logic [twc_pkg::DIM_W-1:0]  w_eff, h_eff, col_inc, row_inc;
  logic                       col_end, row_end, bright;
  logic [twc_pkg::PXP_W-1:0]  px_col, px_row;

  logic [twc_pkg::CNT_W-1:0]     m_eff, diff;
  logic [twc_pkg::M9_W-1:0]      m9;
  logic                          use_w, est_ok;
  logic [twc_pkg::DIV_NUM_W-1:0] div_num, quot;
  logic [twc_pkg::DIV_DEN_W-1:0] div_den;
  logic                          div_done;
  logic [twc_pkg::CEN_W-1:0]     q_sat;
  logic [twc_pkg::CONF_W-1:0]    q_conf;
  logic [twc_pkg::CONF_RAW_W-1:0] conf_raw;
  logic [twc_pkg::CONF_W-1:0]    conf;

  // Frame dimensions are clamped to the supported range.
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = twc_pkg::DIM_W'(1);
    end else if (cfg_i.frame_width > twc_pkg::MAX_WIDTH) begin
      w_eff = twc_pkg::MAX_WIDTH;
    end else begin
      w_eff = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      h_eff = twc_pkg::DIM_W'(1);
    end else if (cfg_i.frame_height > twc_pkg::MAX_HEIGHT) begin
      h_eff = twc_pkg::MAX_HEIGHT;
    end else begin
      h_eff = cfg_i.frame_height;
    end
  end

  assign col_inc = {1'b0, col_q} + twc_pkg::DIM_W'(1);
  assign row_inc = {1'b0, row_q} + twc_pkg::DIM_W'(1);
  assign col_end = col_inc >= w_eff;
  assign row_end = row_inc >= h_eff;
  assign bright  = in_data_i.pixel >= cfg_i.threshold;
  assign px_col  = twc_pkg::PXP_W'(in_data_i.pixel) * twc_pkg::PXP_W'(col_q);
  assign px_row  = twc_pkg::PXP_W'(in_data_i.pixel) * twc_pkg::PXP_W'(row_q);

  always_comb begin
    cnt_d  = cnt_q;
    scol_d = scol_q;
    srow_d = srow_q;
    wt_d   = wt_q;
    wcol_d = wcol_q;
    wrow_d = wrow_q;
    if (bright) begin
      cnt_d  = cnt_q + twc_pkg::CNT_W'(1);
      scol_d = scol_q + twc_pkg::SUM_W'(col_q);
      srow_d = srow_q + twc_pkg::SUM_W'(row_q);
      wt_d   = wt_q + twc_pkg::WT_W'(in_data_i.pixel);
      wcol_d = wcol_q + twc_pkg::WSUM_W'(px_col);
      wrow_d = wrow_q + twc_pkg::WSUM_W'(px_row);
    end
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_inc[twc_pkg::COL_W-1:0];
    end else begin
      col_d = col_inc[twc_pkg::COL_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      scol_q <= '0;
      srow_q <= '0;
      wt_q   <= '0;
      wcol_q <= '0;
      wrow_q <= '0;
    end else if (cmd_i.acc_en) begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.snap) begin
        cnt_q  <= '0;
        scol_q <= '0;
        srow_q <= '0;
        wt_q   <= '0;
        wcol_q <= '0;
        wrow_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        scol_q <= scol_d;
        srow_q <= srow_d;
        wt_q   <= wt_d;
        wcol_q <= wcol_d;
        wrow_q <= wrow_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      s_cnt_q  <= cnt_d;
      s_scol_q <= scol_d;
      s_srow_q <= srow_d;
      s_wt_q   <= wt_d;
      s_wcol_q <= wcol_d;
      s_wrow_q <= wrow_d;
      s_fid_q  <= in_data_i.frame_tag;
    end
  end

  assign m_eff  = (cfg_i.min_bright == '0) ? twc_pkg::CNT_W'(1) : cfg_i.min_bright;
  assign m9     = {1'b0, m_eff, 3'b000} + twc_pkg::M9_W'(m_eff);
  assign diff   = s_cnt_q - m_eff;
  assign use_w  = s_wt_q != '0;
  assign est_ok = (s_cnt_q >= cfg_i.min_bright) && (s_cnt_q != '0);

  always_comb begin
    case (cmd_i.div_sel)
      twc_pkg::DIV_X: begin
        div_num = use_w ? twc_pkg::DIV_NUM_W'({s_wcol_q, {twc_pkg::FRAC_BITS{1'b0}}})
                        : twc_pkg::DIV_NUM_W'({s_scol_q, {twc_pkg::FRAC_BITS{1'b0}}});
        div_den = use_w ? s_wt_q : twc_pkg::DIV_DEN_W'(s_cnt_q);
      end
      twc_pkg::DIV_Y: begin
        div_num = use_w ? twc_pkg::DIV_NUM_W'({s_wrow_q, {twc_pkg::FRAC_BITS{1'b0}}})
                        : twc_pkg::DIV_NUM_W'({s_srow_q, {twc_pkg::FRAC_BITS{1'b0}}});
        div_den = use_w ? s_wt_q : twc_pkg::DIV_DEN_W'(s_cnt_q);
      end
      twc_pkg::DIV_C: begin
        div_num = twc_pkg::DIV_NUM_W'({diff, 16'b0});
        div_den = twc_pkg::DIV_DEN_W'(m9);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  twc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign q_sat    = (quot > twc_pkg::DIV_NUM_W'(twc_pkg::CEN_MAX))
                  ? twc_pkg::CEN_MAX : quot[twc_pkg::CEN_W-1:0];
  assign q_conf   = (quot > twc_pkg::DIV_NUM_W'(twc_pkg::CONF_ONE))
                  ? twc_pkg::CONF_ONE : quot[twc_pkg::CONF_W-1:0];
  assign conf_raw = prod_q[twc_pkg::PROD_W-1:twc_pkg::FRAC_BITS];
  assign conf     = (conf_raw > twc_pkg::CONF_RAW_W'(twc_pkg::CONF_ONE))
                  ? twc_pkg::CONF_ONE : conf_raw[twc_pkg::CONF_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) begin
      cx_q <= q_sat;
    end
    if (cmd_i.cap_y) begin
      cy_q <= q_sat;
    end
    if (cmd_i.cap_c) begin
      c1_q <= q_conf;
    end
    if (cmd_i.mul_en) begin
      prod_q <= twc_pkg::PROD_W'(c1_q) * twc_pkg::PROD_W'(cfg_i.conf_gain);
    end
    if (cmd_i.out_load) begin
      out_q.frame_id_out <= s_fid_q;
      out_q.centroid_x   <= est_ok ? cx_q : '0;
      out_q.centroid_y   <= est_ok ? cy_q : '0;
      out_q.confidence   <= est_ok ? conf : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.frame_last = col_end && row_end;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_full   = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

// ----- rtl/twc_ctrl.sv -----
// Controller: pixel transfer acceptance and the end-of-frame sequence
// that drives the divider, multiplier and result register. Depends on twc_pkg.
module twc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  twc_pkg::ctrl_sts_t  sts_i,
  output twc_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_RUN_X = 7'b0000100,
    ST_RUN_Y = 7'b0001000,
    ST_RUN_C = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_PUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == ST_IDLE) || !sts_i.frame_last;
  assign in_ready_o = ready;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.div_sel    = twc_pkg::DIV_X;
    cmd_o.acc_en     = in_valid_i && ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.frame_last) begin
          cmd_o.snap = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = twc_pkg::DIV_X;
        state_d         = ST_RUN_X;
      end
      ST_RUN_X: begin
        if (sts_i.div_done) begin
          cmd_o.cap_x     = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = twc_pkg::DIV_Y;
          state_d         = ST_RUN_Y;
        end
      end
      ST_RUN_Y: begin
        if (sts_i.div_done) begin
          cmd_o.cap_y     = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = twc_pkg::DIV_C;
          state_d         = ST_RUN_C;
        end
      end
      ST_RUN_C: begin
        if (sts_i.div_done) begin
          cmd_o.cap_c = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_PUT;
      end
      ST_PUT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/thresholded_weighted_centroid.sv -----
// Thresholded weighted centroid top level: register port, controller and datapath.
// Pixels transfer at one per cycle, but a frame's last pixel can be held off (see below).
// After that pixel the result is computed by three divisions on the shared divider, then
// a multiply. That last pixel waits until the previous frame's result has entered the
// output register.
// Reset is asynchronous, active low; it restores the register defaults and clears the frame.
module thresholded_weighted_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  twc_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output twc_pkg::est_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twc_pkg::APB_AW-1:0]    paddr,
  input  logic [twc_pkg::APB_DW-1:0]    pwdata,
  output logic [twc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  twc_pkg::cfg_t      cfg_q;
  twc_pkg::ctrl_cmd_t cmd;
  twc_pkg::ctrl_sts_t sts;
  logic               wr_en;
  logic [twc_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[twc_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= twc_pkg::RST_THRESHOLD;
      cfg_q.min_bright   <= twc_pkg::RST_MIN_PIXELS;
      cfg_q.conf_gain    <= twc_pkg::RST_CONF_SCALE;
      cfg_q.frame_width  <= twc_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height <= twc_pkg::RST_FRAME_HEIGHT;
    end else if (wr_en) begin
      unique case (reg_idx)
        twc_pkg::REG_THRESHOLD:    cfg_q.threshold <= pwdata[twc_pkg::THR_W-1:0];
        twc_pkg::REG_MIN_PIXELS:   cfg_q.min_bright <= pwdata[twc_pkg::CNT_W-1:0];
        twc_pkg::REG_CONF_SCALE:   cfg_q.conf_gain <= pwdata[twc_pkg::SCALE_W-1:0];
        twc_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width <= pwdata[twc_pkg::DIM_W-1:0];
        twc_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[twc_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      twc_pkg::REG_THRESHOLD:    prdata = twc_pkg::APB_DW'(cfg_q.threshold);
      twc_pkg::REG_MIN_PIXELS:   prdata = twc_pkg::APB_DW'(cfg_q.min_bright);
      twc_pkg::REG_CONF_SCALE:   prdata = twc_pkg::APB_DW'(cfg_q.conf_gain);
      twc_pkg::REG_FRAME_WIDTH:  prdata = twc_pkg::APB_DW'(cfg_q.frame_width);
      twc_pkg::REG_FRAME_HEIGHT: prdata = twc_pkg::APB_DW'(cfg_q.frame_height);
      default:                   prdata = '0;
    endcase
  end

  twc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/thresholded_weighted_centroid_checker.sv -----
`timescale 1ns / 1ps
// Checker for thresholded_weighted_centroid: follows register writes and pixel transfers,
// predicts each frame's estimate and compares it with every result transfer.
// Depends on twc_pkg only; the testbench top instantiates it beside the block.
module thresholded_weighted_centroid_checker
  import twc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pix_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  est_out_t          out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o,
  output logic              frame_start_o
);

  logic [THR_W-1:0]   thr;
  logic [CNT_W-1:0]   min_px;
  logic [SCALE_W-1:0] scale;
  logic [DIM_W-1:0]   fw;
  logic [DIM_W-1:0]   fh;

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic [CNT_W-1:0]  bright_cnt;
  logic [SUM_W-1:0]  col_sum;
  logic [SUM_W-1:0]  row_sum;
  logic [WT_W-1:0]   weight_sum;
  logic [WSUM_W-1:0] wcol_sum;
  logic [WSUM_W-1:0] wrow_sum;

  est_out_t estimates_due[$];

  assign frame_start_o = (col == '0) && (row == '0);

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
    if (v == '0) return DIM_W'(1);
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [CEN_W-1:0] fixed_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return '0;
    q = (num << FRAC_BITS) / den;
    if (q > CEN_MAX) return CEN_MAX;
    return q[CEN_W-1:0];
  endfunction

  task automatic clear_frame();
    col        = '0;
    row        = '0;
    bright_cnt = '0;
    col_sum    = '0;
    row_sum    = '0;
    weight_sum = '0;
    wcol_sum   = '0;
    wrow_sum   = '0;
  endtask

  task automatic take_pixel(input pix_in_t p);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [63:0]      m;
    logic [63:0]      c1;
    logic [63:0]      conf;
    est_out_t         e;
    w = eff_dim(fw, MAX_WIDTH);
    h = eff_dim(fh, MAX_HEIGHT);
    if (p.pixel >= thr) begin
      bright_cnt = bright_cnt + CNT_W'(1);
      col_sum    = col_sum + SUM_W'(col);
      row_sum    = row_sum + SUM_W'(row);
      weight_sum = weight_sum + WT_W'(p.pixel);
      wcol_sum   = wcol_sum + WSUM_W'(p.pixel) * WSUM_W'(col);
      wrow_sum   = wrow_sum + WSUM_W'(p.pixel) * WSUM_W'(row);
    end
    if (32'(col) + 1 < 32'(w)) begin
      col = col + COL_W'(1);
    end else begin
      col = '0;
      if (32'(row) + 1 < 32'(h)) begin
        row = row + COL_W'(1);
      end else begin
        e = '0;
        e.frame_id_out = p.frame_tag;
        if (bright_cnt >= min_px && bright_cnt != '0) begin
          if (weight_sum != '0) begin
            e.centroid_x = fixed_quotient(64'(wcol_sum), 64'(weight_sum));
            e.centroid_y = fixed_quotient(64'(wrow_sum), 64'(weight_sum));
          end else begin
            e.centroid_x = fixed_quotient(64'(col_sum), 64'(bright_cnt));
            e.centroid_y = fixed_quotient(64'(row_sum), 64'(bright_cnt));
          end
          m  = (min_px == '0) ? 64'd1 : 64'(min_px);
          c1 = ((64'(bright_cnt) - m) * 64'(CONF_ONE)) / (64'd9 * m);
          if (c1 > 64'(CONF_ONE)) c1 = 64'(CONF_ONE);
          conf = (c1 * 64'(scale)) >> 8;
          if (conf > 64'(CONF_ONE)) conf = 64'(CONF_ONE);
          e.confidence = conf[CONF_W-1:0];
        end
        estimates_due.push_back(e);
        clear_frame();
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [FID_W-1:0] want,
                               input logic [FID_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_estimate(input est_out_t got);
    est_out_t want;
    if (estimates_due.size() == 0) begin
      $display("%0t ns: estimate transfer with none expected, got %p", $time, got);
      fail_count_o++;
    end else begin
      want = estimates_due.pop_front();
      compare_field("frame_id_out", want.frame_id_out, got.frame_id_out);
      compare_field("centroid_x", FID_W'(want.centroid_x), FID_W'(got.centroid_x));
      compare_field("centroid_y", FID_W'(want.centroid_y), FID_W'(got.centroid_y));
      compare_field("confidence", FID_W'(want.confidence), FID_W'(got.confidence));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr    = RST_THRESHOLD;
      min_px = RST_MIN_PIXELS;
      scale  = RST_CONF_SCALE;
      fw     = RST_FRAME_WIDTH;
      fh     = RST_FRAME_HEIGHT;
      clear_frame();
      estimates_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_THRESHOLD:    thr    = pwdata[THR_W-1:0];
          REG_MIN_PIXELS:   min_px = pwdata[CNT_W-1:0];
          REG_CONF_SCALE:   scale  = pwdata[SCALE_W-1:0];
          REG_FRAME_WIDTH:  fw     = pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT: fh     = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_estimate(out_data_i);
      if (in_valid_i && in_ready_i) take_pixel(in_data_i);
      pending_o = estimates_due.size();
    end
  end

endmodule

// ----- bench/thresholded_weighted_centroid_test.sv -----
`timescale 1ns / 1ps
// Testbench top for thresholded_weighted_centroid: clock, reset, register writes,
// pixel stimulus with varied idling, and the verdict.
// Depends on twc_pkg, the block and thresholded_weighted_centroid_checker.
module thresholded_weighted_centroid_test;
  import twc_pkg::*;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  pix_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  est_out_t          out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  logic frame_start;

  int               send_gap   = 0;
  int               recv_stall = 0;
  int               sent_count = 0;
  logic [THR_W-1:0] cur_thr    = RST_THRESHOLD;
  logic [DIM_W-1:0] cur_w      = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] cur_h      = RST_FRAME_HEIGHT;

  thresholded_weighted_centroid uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  thresholded_weighted_centroid_checker estimate_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .frame_start_o (frame_start)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
    if (v == '0) return 1;
    if (v > lim) return 32'(lim);
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1:       return 8'($urandom_range(cur_thr, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic set_idle(input int phase);
    case (phase)
      0:       begin send_gap = 0;  recv_stall = 0;  end
      1:       begin send_gap = 60; recv_stall = 0;  end
      2:       begin send_gap = 0;  recv_stall = 60; end
      default: begin send_gap = 33; recv_stall = 33; end
    endcase
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [FID_W-1:0] fid);
    while ($urandom_range(0, 99) < send_gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.pixel     <= px;
    in_data_i.frame_tag <= fid;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    repeat (eff_dim(cur_w, MAX_WIDTH) * eff_dim(cur_h, MAX_HEIGHT))
      send_pixel(rand_pixel(), $urandom);
  endtask

  task automatic finish_frame();
    while (!frame_start) send_pixel(rand_pixel(), $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [CNT_W-1:0] min_px,
                           input logic [SCALE_W-1:0] scale, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    drain();
    repeat (200) @(negedge clk_i);
    write_reg(REG_THRESHOLD, APB_DW'(thr));
    write_reg(REG_MIN_PIXELS, APB_DW'(min_px));
    write_reg(REG_CONF_SCALE, APB_DW'(scale));
    write_reg(REG_FRAME_WIDTH, APB_DW'(w));
    write_reg(REG_FRAME_HEIGHT, APB_DW'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_thr = thr;
    cur_w   = w;
    cur_h   = h;
  endtask

  initial begin
    logic [THR_W-1:0]   r_thr;
    logic [CNT_W-1:0]   r_min;
    logic [SCALE_W-1:0] r_scale;
    bit                 paused;
    paused = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A plain frame with pixel extremes and the all-ones frame identifier.
    configure(8'd128, 21'd2, 12'd256, 11'd3, 11'd2);
    send_pixel(8'd255, $urandom);
    send_pixel(8'd0, $urandom);
    send_pixel(8'd200, $urandom);
    send_pixel(8'd127, $urandom);
    send_pixel(8'd128, $urandom);
    send_pixel(8'd255, 32'hFFFF_FFFF);

    // Bright pixels of value zero leave the weight sum at zero.
    configure(8'd0, 21'd0, 12'd256, 11'd2, 11'd1);
    send_pixel(8'd0, $urandom);
    send_pixel(8'd0, 32'h0);

    // Zero frame size; no bright pixel with a zero minimum, then a single bright one.
    configure(8'd255, 21'd0, 12'd0, 11'd0, 11'd0);
    send_pixel(8'd254, $urandom);
    send_pixel(8'd255, $urandom);

    // Too few bright pixels for a minimum of 2^20.
    configure(8'd1, 21'h10_0000, 12'd4095, 11'd2, 11'd2);
    send_pixel(8'd255, $urandom);
    send_pixel(8'd1, $urandom);
    send_pixel(8'd0, $urandom);
    send_pixel(8'd128, $urandom);

    // Confidence driven into its clamp.
    configure(8'd10, 21'd1, 12'd4095, 11'd4, 11'd2);
    repeat (8) send_pixel($urandom_range(10, 255), $urandom);

    // Frame size changed part way through a frame.
    configure(8'd100, 21'd1, 12'd128, 11'd4, 11'd3);
    repeat (5) send_pixel(rand_pixel(), $urandom);
    configure(8'd100, 21'd1, 12'd128, 11'd1, 11'd2);
    send_pixel(8'd200, $urandom);

    for (int blk = 0; blk < 8; blk++) begin
      set_idle(blk % 4);
      r_thr   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                            : 8'($urandom_range(0, 255));
      r_min   = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 10));
      r_scale = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                            : 12'($urandom_range(0, 4095));
      configure(r_thr, r_min, r_scale, 11'($urandom_range(0, 6)), 11'($urandom_range(0, 4)));
      sent_count = 0;
      finish_frame();
      while (sent_count < 60) begin
        if (blk == 1 && sent_count >= 35 && !paused) begin
          drain();
          paused = 1'b1;
        end
        send_frame();
      end
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 5)) send_pixel(rand_pixel(), $urandom);
    end

    // Oversized width and height, each cut short by a smaller size part way through.
    set_idle(3);
    finish_frame();
    configure(8'($urandom_range(0, 255)), 21'd1, 12'($urandom_range(0, 4095)),
              11'd2047, 11'd1);
    repeat (20) send_pixel(rand_pixel(), $urandom);
    configure(cur_thr, 21'd1, 12'd4095, 11'd1, 11'd1);
    send_pixel(rand_pixel(), $urandom);
    configure(8'd0, 21'd1, 12'd4095, 11'd1, 11'd2047);
    repeat (20) send_pixel(rand_pixel(), $urandom);
    configure(8'd0, 21'd1000, 12'd4095, 11'd1, 11'd1);
    send_pixel(rand_pixel(), $urandom);

    drain();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/twc_pkg.sv
rtl/twc_div.sv
rtl/twc_dp.sv
rtl/twc_ctrl.sv
rtl/thresholded_weighted_centroid.sv
bench/thresholded_weighted_centroid_checker.sv
bench/thresholded_weighted_centroid_test.sv
